### rtl/assert_macros.svh
// Assertion macros for the key/value line tokeniser.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KVLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define KVLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KVLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define KVLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/kvlt_pkg.sv
// Shared types, constants and helpers for the key/value line tokeniser.
// No dependencies.
`default_nettype none
package kvlt_pkg;

	localparam int MAX_HELD_BLANKS = 32;
	localparam int HELD_CNT_W = $clog2(MAX_HELD_BLANKS + 1);
	localparam int HELD_IDX_W = (MAX_HELD_BLANKS > 1) ? $clog2(MAX_HELD_BLANKS) : 1;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		KIND_NAME  = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_PAIR  = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_NAME,
		CMD_HOLD,
		CMD_VALUE,
		CMD_PAIR,
		CMD_PAIR_END,
		CMD_END
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] chr;
	} cmd_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB);
	endfunction

	function automatic logic is_eol(input logic [7:0] b);
		return (b == CH_LF) || (b == CH_CR);
	endfunction

endpackage
`default_nettype wire

### rtl/kvlt_front.sv
// Front end: tracks the line phase and turns each text word that calls for one into a command.
// Depends on kvlt_pkg.
`default_nettype none
module kvlt_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          text_valid,
	input  wire logic [7:0]    text_byte,
	output logic               text_ready,
	input  wire logic          q_full,
	output logic               push,
	output kvlt_pkg::cmd_t     push_cmd
);

	typedef enum logic [2:0] {
		PH_SKIP     = 3'd0,
		PH_COMMENT  = 3'd1,
		PH_NAME     = 3'd2,
		PH_SEEK     = 3'd3,
		PH_AFTER_EQ = 3'd4,
		PH_VALUE    = 3'd5
	} phase_t;

	phase_t              phase_q, phase_d;
	kvlt_pkg::cmd_op_t   op;
	logic                val_path;
	logic                acc;

	assign text_ready = !q_full;
	assign acc = text_valid && text_ready;

	always_comb begin
		phase_d  = phase_q;
		op       = kvlt_pkg::CMD_NONE;
		val_path = 1'b0;
		unique case (phase_q)
			PH_COMMENT: begin
				if (text_byte == kvlt_pkg::CH_NUL) begin
					op = kvlt_pkg::CMD_END;
					phase_d = PH_SKIP;
				end else if (kvlt_pkg::is_eol(text_byte)) begin
					phase_d = PH_SKIP;
				end
			end
			PH_NAME: begin
				priority if (text_byte == kvlt_pkg::CH_NUL) begin
					op = kvlt_pkg::CMD_END;
					phase_d = PH_SKIP;
				end else if (kvlt_pkg::is_blank(text_byte)) begin
					phase_d = PH_SEEK;
				end else if (kvlt_pkg::is_eol(text_byte)) begin
					phase_d = PH_SKIP;
				end else if (text_byte == kvlt_pkg::CH_EQ) begin
					phase_d = PH_AFTER_EQ;
				end else begin
					op = kvlt_pkg::CMD_NAME;
				end
			end
			PH_SEEK: begin
				priority if (text_byte == kvlt_pkg::CH_NUL) begin
					op = kvlt_pkg::CMD_END;
					phase_d = PH_SKIP;
				end else if (text_byte == kvlt_pkg::CH_EQ) begin
					phase_d = PH_AFTER_EQ;
				end else if (kvlt_pkg::is_eol(text_byte)) begin
					phase_d = PH_SKIP;
				end
			end
			PH_AFTER_EQ: val_path = !kvlt_pkg::is_blank(text_byte);
			PH_VALUE:    val_path = 1'b1;
			default: begin
				phase_d = PH_SKIP;
				priority if (text_byte == kvlt_pkg::CH_NUL) begin
					op = kvlt_pkg::CMD_END;
				end else if (text_byte == kvlt_pkg::CH_HASH) begin
					phase_d = PH_COMMENT;
				end else if (text_byte == kvlt_pkg::CH_EQ) begin
					phase_d = PH_AFTER_EQ;
				end else if (!kvlt_pkg::is_blank(text_byte) &&
						!kvlt_pkg::is_eol(text_byte)) begin
					phase_d = PH_NAME;
					op = kvlt_pkg::CMD_NAME;
				end
			end
		endcase
		if (val_path) begin
			priority if (text_byte == kvlt_pkg::CH_NUL) begin
				op = kvlt_pkg::CMD_PAIR_END;
				phase_d = PH_SKIP;
			end else if (text_byte == kvlt_pkg::CH_HASH) begin
				op = kvlt_pkg::CMD_PAIR;
				phase_d = PH_COMMENT;
			end else if (kvlt_pkg::is_eol(text_byte)) begin
				op = kvlt_pkg::CMD_PAIR;
				phase_d = PH_SKIP;
			end else if (kvlt_pkg::is_blank(text_byte)) begin
				op = kvlt_pkg::CMD_HOLD;
				phase_d = PH_VALUE;
			end else begin
				op = kvlt_pkg::CMD_VALUE;
				phase_d = PH_VALUE;
			end
		end
	end

	assign push = acc && (op != kvlt_pkg::CMD_NONE);
	assign push_cmd.op = op;
	assign push_cmd.chr = text_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
		end else if (acc) begin
			phase_q <= phase_d;
		end
	end

endmodule
`default_nettype wire

### rtl/kvlt_cmd_fifo.sv
// Short command queue between the front and back ends.
// Depends on kvlt_pkg.
`default_nettype none
module kvlt_cmd_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire kvlt_pkg::cmd_t  push_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 head_valid,
	output kvlt_pkg::cmd_t       head
);

	kvlt_pkg::cmd_t                      slot_q [kvlt_pkg::CMDQ_DEPTH];
	logic [kvlt_pkg::CMDQ_PTR_W-1:0]     wr_q, rd_q;
	logic [kvlt_pkg::CMDQ_CNT_W-1:0]     cnt_q;
	logic                                do_pop;

	assign full       = (cnt_q == kvlt_pkg::CMDQ_CNT_W'(kvlt_pkg::CMDQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_q];
	assign do_pop     = pop && head_valid;

	function automatic logic [kvlt_pkg::CMDQ_PTR_W-1:0] nxt(
			input logic [kvlt_pkg::CMDQ_PTR_W-1:0] p);
		return (p == kvlt_pkg::CMDQ_PTR_W'(kvlt_pkg::CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= nxt(wr_q);
			if (do_pop) rd_q <= nxt(rd_q);
			if (push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_cmd;
	end

endmodule
`default_nettype wire

### rtl/kvlt_back.sv
// Back end: holds value blanks, flushes them and drives the token register.
// Depends on kvlt_pkg.
`default_nettype none
module kvlt_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire kvlt_pkg::cmd_t  head,
	output logic                 pop,
	output logic                 token_valid,
	input  wire logic            token_ready,
	output logic [1:0]           token_kind,
	output logic [7:0]           token_byte,
	output logic                 last_of_run
);

	logic                                tab_q [kvlt_pkg::MAX_HELD_BLANKS];
	logic [kvlt_pkg::HELD_CNT_W-1:0]     cnt_q, cnt_d, idx_q, idx_d;
	logic                                second_q, second_d;
	logic                                valid_q, adv, load, ld_last, hold_we;
	kvlt_pkg::kind_t                     kind_q, ld_kind;
	logic [7:0]                          byte_q, ld_byte;

	assign adv = !valid_q || token_ready;

	always_comb begin
		pop      = 1'b0;
		load     = 1'b0;
		ld_kind  = kvlt_pkg::KIND_NAME;
		ld_byte  = '0;
		ld_last  = 1'b0;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		second_d = second_q;
		hold_we  = 1'b0;
		if (head_valid) begin
			unique case (head.op)
				kvlt_pkg::CMD_HOLD: begin
					pop = 1'b1;
					if (cnt_q < kvlt_pkg::HELD_CNT_W'(kvlt_pkg::MAX_HELD_BLANKS)) begin
						hold_we = 1'b1;
						cnt_d = cnt_q + 1'b1;
					end
				end
				kvlt_pkg::CMD_NAME: if (adv) begin
					load = 1'b1; pop = 1'b1;
					ld_kind = kvlt_pkg::KIND_NAME; ld_byte = head.chr; ld_last = 1'b1;
				end
				kvlt_pkg::CMD_VALUE: if (adv) begin
					load = 1'b1;
					ld_kind = kvlt_pkg::KIND_VALUE;
					if (idx_q < cnt_q) begin
						ld_byte = tab_q[idx_q[kvlt_pkg::HELD_IDX_W-1:0]] ?
							kvlt_pkg::CH_TAB : kvlt_pkg::CH_SPACE;
						idx_d = idx_q + 1'b1;
					end else begin
						ld_byte = head.chr; ld_last = 1'b1; pop = 1'b1;
						idx_d = '0; cnt_d = '0;
					end
				end
				kvlt_pkg::CMD_PAIR: if (adv) begin
					load = 1'b1; pop = 1'b1; ld_kind = kvlt_pkg::KIND_PAIR;
					ld_last = 1'b1; cnt_d = '0;
				end
				kvlt_pkg::CMD_END: if (adv) begin
					load = 1'b1; pop = 1'b1; ld_kind = kvlt_pkg::KIND_END;
					ld_last = 1'b1; cnt_d = '0;
				end
				kvlt_pkg::CMD_PAIR_END: if (adv) begin
					load = 1'b1;
					if (!second_q) begin
						ld_kind = kvlt_pkg::KIND_PAIR; second_d = 1'b1;
					end else begin
						ld_kind = kvlt_pkg::KIND_END; ld_last = 1'b1;
						second_d = 1'b0; pop = 1'b1; cnt_d = '0;
					end
				end
				default: pop = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			cnt_q    <= '0;
			idx_q    <= '0;
			second_q <= 1'b0;
		end else begin
			if (adv) valid_q <= load;
			cnt_q    <= cnt_d;
			idx_q    <= idx_d;
			second_q <= second_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= ld_kind;
			byte_q <= ld_byte;
			last_of_run <= ld_last;
		end
		if (hold_we) tab_q[cnt_q[kvlt_pkg::HELD_IDX_W-1:0]] <= (head.chr == kvlt_pkg::CH_TAB);
	end

	assign token_valid = valid_q;
	assign token_kind  = kind_q;
	assign token_byte  = byte_q;

endmodule
`default_nettype wire

### rtl/key_value_line_tokenizer_core.sv
// Key/value line tokeniser: front end, command queue, back end.
// Throughput: one text word per cycle while the command queue is not full; the back
// end gives one token per cycle while token_ready allows, so a value character after
// n held blanks yields n+1 tokens, and end of text in a value a pair and an end token.
// Reset (arst_n low, asynchronous): skip-whitespace phase, empty queue, no held blanks.
`default_nettype none
`include "assert_macros.svh"
module key_value_line_tokenizer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        text_valid,
	output logic             text_ready,
	input  wire logic [7:0]  text_byte,
	output logic             token_valid,
	input  wire logic        token_ready,
	output logic [1:0]       token_kind,
	output logic [7:0]       token_byte,
	output logic             last_of_run
);

	logic            q_full, push, pop, head_valid;
	kvlt_pkg::cmd_t  push_cmd, head;

	kvlt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_byte  (text_byte),
		.text_ready (text_ready),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	kvlt_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	kvlt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_kind  (token_kind),
		.token_byte  (token_byte),
		.last_of_run (last_of_run)
	);

	`KVLT_ASSERT_IMP(a_end_is_last, clk, arst_n, token_valid && (token_kind == kvlt_pkg::KIND_END), last_of_run, "end of text not last of run")
	`KVLT_ASSERT_IMP(a_mark_byte_zero, clk, arst_n, token_valid && ((token_kind == kvlt_pkg::KIND_END) || (token_kind == kvlt_pkg::KIND_PAIR)), token_byte == 8'h00, "marker word carries a byte")
	`KVLT_ASSERT_NXT(a_pair_then_end, clk, arst_n, token_valid && token_ready && (token_kind == kvlt_pkg::KIND_PAIR) && !last_of_run, token_valid && (token_kind == kvlt_pkg::KIND_END), "pair mark not followed by end")

endmodule
`default_nettype wire
